[hdl/quadrature_position_speed_estimator_macros.svh]
// assertion macros for the position and speed estimator
`ifndef QUADRATURE_POSITION_SPEED_ESTIMATOR_MACROS_SVH
`define QUADRATURE_POSITION_SPEED_ESTIMATOR_MACROS_SVH

// consequent checked in the same cycle
`define QPSE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define QPSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/qpse_pkg.sv]
`timescale 1ns / 1ps

package qpse_pkg;

    localparam int CNT_WIDTH_DEF = 32;
    localparam int MEDIAN_TAPS   = 3;
    localparam int SLOT_W        = 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // input command codes
    localparam logic [1:0] CMD_EDGE_A = 2'd0;
    localparam logic [1:0] CMD_EDGE_B = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_COUNTS_PER_REV   = 2'd0;
    localparam logic [1:0] REG_DEGREES_PER_TICK = 2'd1;
    localparam logic [1:0] REG_RPM_PER_COUNT    = 2'd2;
    localparam logic [1:0] REG_EMA_ALPHA        = 2'd3;

    localparam logic [15:0] COUNTS_PER_REV_RST   = 16'd1440;
    localparam logic [23:0] DEGREES_PER_TICK_RST = 24'd16384;
    localparam logic [23:0] RPM_PER_COUNT_RST    = 24'd136533;
    localparam logic [16:0] EMA_ALPHA_RST        = 17'd11796;
    localparam logic [16:0] EMA_ONE              = 17'd65536;

    localparam logic signed [23:0] SPEED_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SPEED_MIN = 24'sh800000;
    localparam logic [16:0]        ANGLE_MAX = 17'd92159;

    // raw speed magnitude is clamped to 2^38 counts
    localparam int          SPD_MAG_W     = 39;
    localparam logic [63:0] SPD_MAG_CLAMP = 64'h0000_0040_0000_0000;

    typedef enum logic [1:0] {
        OP_UP,
        OP_DOWN,
        OP_TICK,
        OP_NOP
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SPD_MAG,
        ST_SPD_LO,
        ST_SPD_HI,
        ST_SPD_SUM,
        ST_SPD_SAT,
        ST_MEDIAN,
        ST_EMA_A,
        ST_EMA_B,
        ST_EMA_SUM,
        ST_EMA_MAG,
        ST_EMA_SAT,
        ST_POS_INIT,
        ST_POS_DIV,
        ST_POS_FIX,
        ST_ANGLE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       pin_a;
        logic       pin_b;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] tick_count;
        logic [16:0]        angle;
        logic signed [23:0] rpm;
    } out_item_t;

    typedef struct packed {
        logic [15:0] counts_per_rev;
        logic [23:0] degrees_per_tick;
        logic [23:0] rpm_per_count;
        logic [16:0] ema_alpha;
    } cfg_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } qentry_t;

endpackage

[hdl/quadrature_position_speed_estimator.sv]
`timescale 1ns / 1ps

// channel   direction   payload                 handshake
// sample    in          in_item_t               sample_valid / sample_stall
// report    out         out_item_t              report_valid / report_stall
// config    in          cfg_index, cfg_data     cfg_write
//
// an edge or unused-code item passes in the back end through the remainder unit,
// which retires one count bit per cycle
// for a speed tick, split multiply and filter steps come first
// after reset the state, count, filter and output registers hold their reset values, no clearing pass
// a two-entry queue keeps taking items until full while the back end works, and the result
// register holds a finished item under report_stall while the next one proceeds

module quadrature_position_speed_estimator
    import qpse_pkg::*;
#(
    parameter int COUNT_WIDTH = CNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  in_item_t    sample,
    output logic        report_valid,
    input  logic        report_stall,
    output out_item_t   report,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    qentry_t push;
    qentry_t head;
    logic    full;
    logic    pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_COUNTS_PER_REV:   cfg_next.counts_per_rev   = cfg_data[15:0];
                REG_DEGREES_PER_TICK: cfg_next.degrees_per_tick = cfg_data;
                REG_RPM_PER_COUNT:    cfg_next.rpm_per_count    = cfg_data;
                REG_EMA_ALPHA:        cfg_next.ema_alpha        = cfg_data[16:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.counts_per_rev   <= COUNTS_PER_REV_RST;
            cfg_reg.degrees_per_tick <= DEGREES_PER_TICK_RST;
            cfg_reg.rpm_per_count    <= RPM_PER_COUNT_RST;
            cfg_reg.ema_alpha        <= EMA_ALPHA_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    qpse_front u_front (
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .full         (full),
        .push         (push)
    );

    qpse_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .head  (head),
        .pop   (pop)
    );

    qpse_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .pop          (pop),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report)
    );

endmodule

[hdl/qpse_front.sv]
`timescale 1ns / 1ps

module qpse_front
    import qpse_pkg::*;
(
    input  logic     sample_valid,
    output logic     sample_stall,
    input  in_item_t sample,
    input  logic     full,
    output qentry_t  push
);

    op_t op;

    always_comb
    begin
        case (sample.cmd)
            CMD_EDGE_A: op = (sample.pin_a == sample.pin_b) ? OP_UP : OP_DOWN;
            CMD_EDGE_B: op = (sample.pin_a != sample.pin_b) ? OP_UP : OP_DOWN;
            CMD_TICK:   op = OP_TICK;
            default:    op = OP_NOP;
        endcase
    end

    assign sample_stall = full;
    assign push.valid   = sample_valid && !full;
    assign push.op      = op;

endmodule

[hdl/qpse_fifo.sv]
`timescale 1ns / 1ps

module qpse_fifo
    import qpse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  qentry_t push,
    output logic    full,
    output qentry_t head,
    input  logic    pop
);

    op_t               q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.op    = q_mem[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + QCNT_W'(1);
            2'b01:   cnt_next = cnt_reg - QCNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push.op;
        end
    end

endmodule

[hdl/qpse_back.sv]
`timescale 1ns / 1ps

module qpse_back
    import qpse_pkg::*;
#(
    parameter int COUNT_WIDTH = CNT_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  qentry_t   head,
    output logic      pop,
    output logic      report_valid,
    input  logic      report_stall,
    output out_item_t report
);

    localparam int W      = COUNT_WIDTH;
    localparam int BITS_W = $clog2(COUNT_WIDTH + 1);

    state_t state_reg, state_next;

    logic [W-1:0]      count_reg, count_next;
    logic [W-1:0]      last_reg, last_next;
    logic [W-1:0]      delta_reg, delta_next;
    logic [W-1:0]      dvd_reg, dvd_next;
    logic [BITS_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [15:0]       rem_reg, rem_next;
    logic [15:0]       pos_reg, pos_next;
    logic [39:0]       aprod_reg, aprod_next;
    logic [SPD_MAG_W-1:0] mag_reg, mag_next;
    logic [43:0]       pp_lo_reg, pp_lo_next;
    logic [42:0]       pp_hi_reg, pp_hi_next;
    logic [54:0]       spdq_reg, spdq_next;
    logic signed [23:0] ring_reg [MEDIAN_TAPS];
    logic signed [23:0] ring_next [MEDIAN_TAPS];
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic signed [23:0] med_reg, med_next;
    logic signed [23:0] smooth_reg, smooth_next;
    logic signed [41:0] pa_reg, pa_next;
    logic signed [41:0] pb_reg, pb_next;
    logic signed [42:0] s_reg, s_next;
    logic [26:0]       emag_reg, emag_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [15:0]        tdiv;
    logic [16:0]        al;
    logic [16:0]        bl;
    logic signed [17:0] al_s;
    logic signed [17:0] bl_s;
    logic signed [63:0] tc_wide;
    logic [16:0]        trial;
    logic [W-1:0]       mag_w;
    logic [62:0]        spd_sum;
    logic [42:0]        em_sum;
    logic [40:0]        ang_sum;
    logic [32:0]        ang_q;
    logic [SLOT_W-1:0]  slot_eff;
    logic signed [23:0] raw;

    function automatic logic signed [23:0] median3(
        input logic signed [23:0] a,
        input logic signed [23:0] b,
        input logic signed [23:0] c
    );
        logic signed [23:0] lo;
        logic signed [23:0] hi;
        logic signed [23:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (c < hi) ? c : hi;
        return (lo > m) ? lo : m;
    endfunction

    // zero modulus acts as one, alpha above one acts as one
    assign tdiv    = (cfg.counts_per_rev == '0) ? 16'd1 : cfg.counts_per_rev;
    assign al      = (cfg.ema_alpha > EMA_ONE) ? EMA_ONE : cfg.ema_alpha;
    assign bl      = EMA_ONE - al;
    assign al_s    = $signed({1'b0, al});
    assign bl_s    = $signed({1'b0, bl});
    assign tc_wide = 64'($signed(count_reg));

    assign report_valid = out_valid_reg;
    assign report       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        delta_next     = delta_reg;
        dvd_next       = dvd_reg;
        bit_cnt_next   = bit_cnt_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        aprod_next     = aprod_reg;
        mag_next       = mag_reg;
        pp_lo_next     = pp_lo_reg;
        pp_hi_next     = pp_hi_reg;
        spdq_next      = spdq_reg;
        ring_next      = ring_reg;
        slot_next      = slot_reg;
        med_next       = med_reg;
        smooth_next    = smooth_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        s_next         = s_reg;
        emag_next      = emag_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        pop            = 1'b0;
        trial          = '0;
        mag_w          = '0;
        spd_sum        = '0;
        em_sum         = '0;
        ang_sum        = '0;
        ang_q          = '0;
        slot_eff       = '0;
        raw            = '0;

        if (out_valid_reg && !report_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (head.op)
                        OP_UP:
                        begin
                            count_next = count_reg + W'(1);
                            state_next = ST_POS_INIT;
                        end
                        OP_DOWN:
                        begin
                            count_next = count_reg - W'(1);
                            state_next = ST_POS_INIT;
                        end
                        OP_TICK:
                        begin
                            delta_next = count_reg - last_reg;
                            last_next  = count_reg;
                            state_next = ST_SPD_MAG;
                        end
                        default:
                        begin
                            state_next = ST_POS_INIT;
                        end
                    endcase
                end
            end
            ST_SPD_MAG:
            begin
                mag_w = delta_reg[W-1] ? (~delta_reg) + W'(1) : delta_reg;
                if (64'(mag_w) > SPD_MAG_CLAMP)
                begin
                    mag_next = SPD_MAG_W'(SPD_MAG_CLAMP);
                end
                else
                begin
                    mag_next = SPD_MAG_W'(mag_w);
                end
                state_next = ST_SPD_LO;
            end
            // magnitude times scale in two partial products
            ST_SPD_LO:
            begin
                pp_lo_next = mag_reg[19:0] * cfg.rpm_per_count;
                state_next = ST_SPD_HI;
            end
            ST_SPD_HI:
            begin
                pp_hi_next = mag_reg[SPD_MAG_W-1:20] * cfg.rpm_per_count;
                state_next = ST_SPD_SUM;
            end
            ST_SPD_SUM:
            begin
                spd_sum    = {pp_hi_reg, 20'b0} + 63'(pp_lo_reg) + 63'd128;
                spdq_next  = spd_sum[62:8];
                state_next = ST_SPD_SAT;
            end
            ST_SPD_SAT:
            begin
                if (delta_reg[W-1])
                begin
                    raw = (spdq_reg >= 55'd8388608) ? SPEED_MIN
                                                    : -$signed(spdq_reg[23:0]);
                end
                else
                begin
                    raw = (spdq_reg > 55'(SPEED_MAX)) ? SPEED_MAX
                                                      : $signed(spdq_reg[23:0]);
                end
                // a slot past the end restarts at entry zero
                slot_eff = (slot_reg > SLOT_W'(MEDIAN_TAPS - 1)) ? '0 : slot_reg;
                for (int i = 0; i < MEDIAN_TAPS; i++)
                begin
                    if (slot_eff == SLOT_W'(i))
                    begin
                        ring_next[i] = raw;
                    end
                end
                slot_next  = (slot_eff == SLOT_W'(MEDIAN_TAPS - 1)) ? '0
                                                                    : slot_eff + SLOT_W'(1);
                state_next = ST_MEDIAN;
            end
            ST_MEDIAN:
            begin
                med_next   = median3(ring_reg[0], ring_reg[1], ring_reg[2]);
                state_next = ST_EMA_A;
            end
            ST_EMA_A:
            begin
                pa_next    = al_s * med_reg;
                state_next = ST_EMA_B;
            end
            ST_EMA_B:
            begin
                pb_next    = bl_s * smooth_reg;
                state_next = ST_EMA_SUM;
            end
            ST_EMA_SUM:
            begin
                s_next     = 43'(pa_reg) + 43'(pb_reg);
                state_next = ST_EMA_MAG;
            end
            // |s| + half in one add: for negative s that is ~s + 1 + half
            ST_EMA_MAG:
            begin
                em_sum     = s_reg[42] ? (~s_reg) + 43'd32769 : s_reg + 43'd32768;
                emag_next  = em_sum[42:16];
                state_next = ST_EMA_SAT;
            end
            ST_EMA_SAT:
            begin
                if (s_reg[42])
                begin
                    smooth_next = (emag_reg >= 27'd8388608) ? SPEED_MIN
                                                            : -$signed(emag_reg[23:0]);
                end
                else
                begin
                    smooth_next = (emag_reg > 27'(SPEED_MAX)) ? SPEED_MAX
                                                              : $signed(emag_reg[23:0]);
                end
                state_next = ST_POS_INIT;
            end
            ST_POS_INIT:
            begin
                dvd_next     = count_reg[W-1] ? (~count_reg) + W'(1) : count_reg;
                rem_next     = '0;
                bit_cnt_next = BITS_W'(W);
                state_next   = ST_POS_DIV;
            end
            // restoring remainder, one dividend bit a cycle
            ST_POS_DIV:
            begin
                trial = {rem_reg, dvd_reg[W-1]};
                if (trial >= {1'b0, tdiv})
                begin
                    rem_next = 16'(trial - {1'b0, tdiv});
                end
                else
                begin
                    rem_next = trial[15:0];
                end
                dvd_next     = dvd_reg << 1;
                bit_cnt_next = bit_cnt_reg - BITS_W'(1);
                if (bit_cnt_reg == BITS_W'(1))
                begin
                    state_next = ST_POS_FIX;
                end
            end
            ST_POS_FIX:
            begin
                pos_next   = (count_reg[W-1] && rem_reg != '0) ? tdiv - rem_reg : rem_reg;
                state_next = ST_ANGLE;
            end
            ST_ANGLE:
            begin
                aprod_next = pos_reg * cfg.degrees_per_tick;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                ang_sum = 41'(aprod_reg) + 41'd128;
                ang_q   = ang_sum[40:8];
                if (!out_valid_reg || !report_stall)
                begin
                    out_next.tick_count = tc_wide[31:0];
                    out_next.angle      = (ang_q > 33'(ANGLE_MAX)) ? ANGLE_MAX : ang_q[16:0];
                    out_next.rpm        = smooth_reg;
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            last_reg      <= '0;
            slot_reg      <= '0;
            smooth_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int i = 0; i < MEDIAN_TAPS; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            slot_reg      <= slot_next;
            smooth_reg    <= smooth_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            ring_reg      <= ring_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg   <= delta_next;
        dvd_reg     <= dvd_next;
        bit_cnt_reg <= bit_cnt_next;
        rem_reg     <= rem_next;
        pos_reg     <= pos_next;
        aprod_reg   <= aprod_next;
        mag_reg     <= mag_next;
        pp_lo_reg   <= pp_lo_next;
        pp_hi_reg   <= pp_hi_next;
        spdq_reg    <= spdq_next;
        med_reg     <= med_next;
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        s_reg       <= s_next;
        emag_reg    <= emag_next;
    end

endmodule

[hdl/qpse_checker.sv]
`timescale 1ns / 1ps
`include "quadrature_position_speed_estimator_macros.svh"

module qpse_checker
    import qpse_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      report_valid,
    input logic      report_stall,
    input out_item_t report
);

    `QPSE_ASSERT_NEXT(a_report_hold, report_valid && report_stall,
                      report_valid && $stable(report), "stalled report item changed")
    `QPSE_ASSERT_SAME(a_report_drop, $fell(report_valid), $past(!report_stall),
                      "report item dropped while stalled")
    // an item moves either the count or the speed, never both
    `QPSE_ASSERT_SAME(a_count_or_speed, report.tick_count != $past(report.tick_count),
                      report.rpm == $past(report.rpm), "count and speed changed in one item")
    `QPSE_ASSERT_SAME(a_angle_range, report_valid, report.angle <= ANGLE_MAX,
                      "angle beyond one revolution")

endmodule

bind quadrature_position_speed_estimator qpse_checker u_qpse_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import qpse_pkg::*;

    localparam int COUNT_W     = 32;
    localparam int SETTLE_CYC  = COUNT_W + 24;
    localparam int DRAIN_LIMIT = 200000;
    localparam int HOLD_CYC    = 400;
    localparam int N_DIRECTED  = 20;
    localparam int N_SEGMENTS  = 8;
    localparam int SEG_ITEMS   = 120;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        sample_valid = 1'b0;
    logic        sample_stall;
    in_item_t    sample       = '0;
    logic        report_valid;
    logic        report_stall = 1'b0;
    out_item_t   report;
    logic        cfg_write    = 1'b0;
    logic [1:0]  cfg_index    = REG_COUNTS_PER_REV;
    logic [23:0] cfg_data     = '0;

    // shadow copy of the estimator state
    cfg_t               shadow_cfg;
    logic [31:0]        enc_count;
    logic [31:0]        count_at_tick;
    logic [15:0]        rev_pos;
    logic signed [23:0] speed_ring [MEDIAN_TAPS];
    logic [1:0]         ring_ptr;
    logic signed [23:0] speed_avg;
    logic               quad_a;
    logic               quad_b;

    out_item_t pending_reports [$];
    out_item_t oldest;
    dir_row_t  rows [N_DIRECTED];
    int        fail_count = 0;
    int        send_pct   = 0;
    int        recv_pct   = 0;
    int        hold_ask   = 0;
    int        hold_seen  = 0;
    int        hold_left  = 0;

    quadrature_position_speed_estimator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [15:0] wrap_position(logic [31:0] c, logic [15:0] t);
        logic [31:0] modulus;
        logic [31:0] mag;
        logic [31:0] rem;
        modulus = (t == '0) ? 32'd1 : 32'(t);
        if (c[31])
        begin
            mag = -c;
            rem = mag % modulus;
            return (rem == '0) ? 16'd0 : 16'(modulus - rem);
        end
        return 16'(c % modulus);
    endfunction

    function automatic logic signed [23:0] scale_speed(logic [31:0] delta, logic [23:0] rpc);
        logic [31:0] mag;
        logic [63:0] q;
        mag = delta[31] ? -delta : delta;
        q   = (64'(mag) * 64'(rpc) + 64'd128) >> 8;
        if (rpc == '0)
            return '0;
        if (delta[31])
            return (q >= 64'd8388608) ? SPEED_MIN : 24'(-q);
        return (q > 64'd8388607) ? SPEED_MAX : q[23:0];
    endfunction

    function automatic logic signed [23:0] median_of3(logic signed [23:0] x,
                                                      logic signed [23:0] y,
                                                      logic signed [23:0] z);
        if ((x <= y && y <= z) || (z <= y && y <= x))
            return y;
        if ((y <= x && x <= z) || (z <= x && x <= y))
            return x;
        return z;
    endfunction

    function automatic logic signed [23:0] smooth_speed(logic signed [23:0] med,
                                                        logic signed [23:0] prev,
                                                        logic [16:0] alpha);
        logic signed [63:0] wt;
        logic signed [63:0] acc;
        logic signed [63:0] q;
        wt  = (alpha > EMA_ONE) ? 64'sd65536 : $signed(64'(alpha));
        acc = wt * med + (64'sd65536 - wt) * prev;
        // round half away from zero
        if (acc >= 0)
            q = (acc + 64'sd32768) >>> 16;
        else
            q = -((-acc + 64'sd32768) >>> 16);
        if (q > 64'sd8388607)
            q = 64'sd8388607;
        if (q < -64'sd8388608)
            q = -64'sd8388608;
        return q[23:0];
    endfunction

    function automatic logic [16:0] angle_of(logic [15:0] pos, logic [23:0] dpt);
        logic [63:0] a;
        a = (64'(pos) * 64'(dpt) + 64'd128) >> 8;
        return (a > 64'(ANGLE_MAX)) ? ANGLE_MAX : a[16:0];
    endfunction

    function automatic out_item_t predict_report(in_item_t it);
        logic [31:0] delta;
        out_item_t   r;
        case (it.cmd)
            CMD_EDGE_A:
                enc_count = (it.pin_a == it.pin_b) ? enc_count + 32'd1 : enc_count - 32'd1;
            CMD_EDGE_B:
                enc_count = (it.pin_a != it.pin_b) ? enc_count + 32'd1 : enc_count - 32'd1;
            CMD_TICK:
            begin
                delta         = enc_count - count_at_tick;
                count_at_tick = enc_count;
                speed_ring[ring_ptr] = scale_speed(delta, shadow_cfg.rpm_per_count);
                ring_ptr = (ring_ptr == SLOT_W'(MEDIAN_TAPS - 1)) ? '0 : ring_ptr + 2'd1;
                speed_avg = smooth_speed(median_of3(speed_ring[0], speed_ring[1], speed_ring[2]),
                                         speed_avg, shadow_cfg.ema_alpha);
            end
            default: ;
        endcase
        rev_pos      = wrap_position(enc_count, shadow_cfg.counts_per_rev);
        r.tick_count = enc_count;
        r.angle      = angle_of(rev_pos, shadow_cfg.degrees_per_tick);
        r.rpm        = speed_avg;
        return r;
    endfunction

    function automatic cfg_t make_cfg(logic [15:0] t, logic [23:0] d, logic [23:0] r,
                                      logic [16:0] a);
        cfg_t c;
        c.counts_per_rev   = t;
        c.degrees_per_tick = d;
        c.rpm_per_count    = r;
        c.ema_alpha        = a;
        return c;
    endfunction

    function automatic dir_row_t dir_row(logic [1:0] cmd, logic a, logic b, logic typed,
                                         logic signed [31:0] tc, logic [16:0] ang);
        dir_row_t row;
        row.item.cmd        = cmd;
        row.item.pin_a      = a;
        row.item.pin_b      = b;
        row.typed           = typed;
        row.want.tick_count = tc;
        row.want.angle      = ang;
        row.want.rpm        = '0;
        return row;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_COUNTS_PER_REV:   shadow_cfg.counts_per_rev   = val[15:0];
            REG_DEGREES_PER_TICK: shadow_cfg.degrees_per_tick = val;
            REG_RPM_PER_COUNT:    shadow_cfg.rpm_per_count    = val;
            REG_EMA_ALPHA:        shadow_cfg.ema_alpha        = val[16:0];
            default: ;
        endcase
    endtask

    task automatic load_config(cfg_t c);
        write_reg(REG_COUNTS_PER_REV, 24'(c.counts_per_rev));
        write_reg(REG_DEGREES_PER_TICK, c.degrees_per_tick);
        write_reg(REG_RPM_PER_COUNT, c.rpm_per_count);
        write_reg(REG_EMA_ALPHA, 24'(c.ema_alpha));
        cfg_write <= 1'b0;
    endtask

    task automatic send_item(in_item_t it, logic typed, out_item_t want);
        out_item_t predicted;
        while ($urandom_range(0, 99) < send_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= it;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        predicted = predict_report(it);
        pending_reports.push_back(typed ? want : predicted);
    endtask

    task automatic run_segment(int n_items, int long_pct);
        int       sent;
        int       len;
        logic     up;
        in_item_t it;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                len = ($urandom_range(0, 99) < long_pct) ? $urandom_range(130, 200)
                                                          : $urandom_range(0, 12);
                // keep the run and its tick inside the segment budget
                if (len > n_items - sent - 1)
                    len = n_items - sent - 1;
                up  = 1'($urandom_range(0, 1));
                repeat (len)
                begin
                    // clean quadrature: moving up toggles b when levels match, else a
                    if ((quad_a == quad_b) == up)
                    begin
                        quad_b = ~quad_b;
                        it.cmd = CMD_EDGE_B;
                    end
                    else
                    begin
                        quad_a = ~quad_a;
                        it.cmd = CMD_EDGE_A;
                    end
                    it.pin_a = quad_a;
                    it.pin_b = quad_b;
                    send_item(it, 1'b0, '0);
                    sent++;
                end
                it.cmd   = CMD_TICK;
                it.pin_a = 1'($urandom_range(0, 1));
                it.pin_b = 1'($urandom_range(0, 1));
                send_item(it, 1'b0, '0);
                sent++;
            end
            else
            begin
                // noise item, breaks the quadrature sequence
                it = in_item_t'(4'($urandom_range(0, 15)));
                send_item(it, 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic drain_reports();
        int waited;
        waited = 0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    initial
    begin
        shadow_cfg    = make_cfg(COUNTS_PER_REV_RST, DEGREES_PER_TICK_RST, RPM_PER_COUNT_RST,
                                 EMA_ALPHA_RST);
        enc_count     = '0;
        count_at_tick = '0;
        rev_pos       = '0;
        foreach (speed_ring[i])
            speed_ring[i] = '0;
        ring_ptr      = '0;
        speed_avg     = '0;
        quad_a        = 1'b0;
        quad_b        = 1'b0;

        // reset config: angle is 64 per count, 1439 counts is 92096
        rows = '{
            dir_row(CMD_UNUSED, 1'b1, 1'b1, 1'b1, 32'sd0, 17'd0),
            dir_row(CMD_EDGE_A, 1'b0, 1'b0, 1'b1, 32'sd1, 17'd64),
            dir_row(CMD_EDGE_A, 1'b1, 1'b0, 1'b1, 32'sd0, 17'd0),
            dir_row(CMD_EDGE_A, 1'b0, 1'b1, 1'b1, -32'sd1, 17'd92096),
            dir_row(CMD_EDGE_B, 1'b0, 1'b1, 1'b1, 32'sd0, 17'd0),
            dir_row(CMD_EDGE_B, 1'b1, 1'b1, 1'b0, 32'sd0, 17'd0),
            dir_row(CMD_EDGE_B, 1'b0, 1'b0, 1'b0, 32'sd0, 17'd0),
            dir_row(CMD_EDGE_B, 1'b1, 1'b0, 1'b0, 32'sd0, 17'd0),
            dir_row(CMD_EDGE_A, 1'b1, 1'b1, 1'b0, 32'sd0, 17'd0),
            dir_row(CMD_TICK,   1'b0, 1'b0, 1'b1, 32'sd0, 17'd0),
            dir_row(CMD_UNUSED, 1'b0, 1'b0, 1'b0, 32'sd0, 17'd0),
            dir_row(CMD_EDGE_A, 1'b1, 1'b1, 1'b0, 32'sd0, 17'd0),
            dir_row(CMD_EDGE_A, 1'b0, 1'b0, 1'b0, 32'sd0, 17'd0),
            dir_row(CMD_EDGE_A, 1'b1, 1'b1, 1'b0, 32'sd0, 17'd0),
            dir_row(CMD_EDGE_A, 1'b0, 1'b0, 1'b0, 32'sd0, 17'd0),
            dir_row(CMD_EDGE_B, 1'b1, 1'b0, 1'b0, 32'sd0, 17'd0),
            dir_row(CMD_TICK,   1'b1, 1'b1, 1'b0, 32'sd0, 17'd0),
            dir_row(CMD_TICK,   1'b0, 1'b1, 1'b0, 32'sd0, 17'd0),
            dir_row(CMD_UNUSED, 1'b1, 1'b0, 1'b0, 32'sd0, 17'd0),
            dir_row(CMD_TICK,   1'b1, 1'b0, 1'b0, 32'sd0, 17'd0)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pct = 19;
        recv_pct <= 64;
        foreach (rows[i])
            send_item(rows[i].item, rows[i].typed, rows[i].want);
        sample_valid <= 1'b0;

        for (int seg = 0; seg < N_SEGMENTS; seg++)
        begin
            drain_reports();
            case (seg)
                0: load_config(make_cfg(COUNTS_PER_REV_RST, DEGREES_PER_TICK_RST,
                                        RPM_PER_COUNT_RST, EMA_ALPHA_RST));
                1: load_config(make_cfg(16'd0, 24'hFFFFFF, 24'hFFFFFF, EMA_ONE));
                2: load_config(make_cfg(16'd1, 24'd0, 24'd0, 17'd0));
                3: load_config(make_cfg(16'hFFFF, 24'hFFFFFF, 24'd256, 17'h1FFFF));
                4: load_config(make_cfg(16'd360, 24'd65536,
                                        24'($urandom_range(0, 16777215)), 17'd32768));
                6: load_config(make_cfg(16'd7, 24'd3370423, 24'hFFFFFF, 17'd1));
                default: load_config(make_cfg(16'($urandom_range(1, 65535)),
                                              24'($urandom_range(0, 16777215)),
                                              24'($urandom_range(0, 16777215)),
                                              17'($urandom_range(0, 131071))));
            endcase
            send_pct = (seg < 3) ? 19 : (seg < 6) ? 64 : 0;
            recv_pct <= (seg < 3) ? 64 : (seg < 6) ? 19 : 0;
            // long receiver hold-off while items keep coming
            if (seg == 6)
                hold_ask <= hold_ask + 1;
            run_segment(SEG_ITEMS, (seg == 1) ? 50 : 12);
            sample_valid <= 1'b0;
        end

        drain_reports();
        if (fail_count == 0 && pending_reports.size() == 0)
            $display("quadrature_position_speed_estimator test passed");
        else
            $display("quadrature_position_speed_estimator test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            report_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (hold_ask != hold_seen)
        begin
            hold_seen    <= hold_ask;
            hold_left    <= HOLD_CYC;
            report_stall <= 1'b1;
        end
        else
            report_stall <= ($urandom_range(0, 99) < recv_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && report_valid && !report_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("report item with none pending: tick_count %0d angle %0d rpm %0d",
                             report.tick_count, report.angle, report.rpm);
            end
            else
            begin
                oldest = pending_reports.pop_front();
                if (report.tick_count !== oldest.tick_count || report.angle !== oldest.angle
                    || report.rpm !== oldest.rpm)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("report mismatch (exp/got): tick_count %0d/%0d angle %0d/%0d rpm %0d/%0d",
                                 oldest.tick_count, report.tick_count, oldest.angle,
                                 report.angle, oldest.rpm, report.rpm);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("quadrature_position_speed_estimator test failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/qpse_pkg.sv
hdl/qpse_front.sv
hdl/qpse_fifo.sv
hdl/qpse_back.sv
hdl/quadrature_position_speed_estimator.sv
hdl/qpse_checker.sv
test/tb_top.sv
